FILE: hw/rtl/tkri_pkg.sv
// Shared types and constants for the top-k ranking insert block.
// No dependencies; imported by every module of the block.
package tkri_pkg;

   localparam int MAX_RANK_DEF = 16;
   localparam int SCORE_W      = 32;
   localparam int INDEX_W      = 32;
   localparam int RANK_W       = 5;
   localparam int POS_W        = 4;

   localparam logic [RANK_W-1:0] RANK_RESET = 5'd16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_INSERT,
      ST_LOAD,
      ST_LIST
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic compare;
      logic insert;
      logic load;
      logic emit;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic list_done;
   } status_type;

endpackage

FILE: hw/rtl/tkri_ctrl.sv
// Sequencer for the top-k ranking insert block.
// Depends on tkri_pkg for the state, command and status types.
module tkri_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  tkri_pkg::status_type status,
   output tkri_pkg::cmd_type    cmd,
   output logic                 busy,
   output logic                 rsp_valid
);
   import tkri_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_COMPARE;
         end
         ST_COMPARE: state_in = ST_INSERT;
         ST_INSERT:  state_in = ST_LOAD;
         ST_LOAD:    state_in = ST_LIST;
         ST_LIST: begin
            if (status.list_done) state_in = ST_IDLE;
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         ST_COMPARE: cmd.compare = 1'b1;
         ST_INSERT:  cmd.insert  = 1'b1;
         ST_LOAD:    cmd.load    = 1'b1;
         ST_LIST: begin
            cmd.emit  = 1'b1;
            rsp_valid = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

FILE: hw/rtl/tkri_datapath.sv
// Ranking table, insert logic and listing shift line.
// Depends on tkri_pkg; driven by tkri_ctrl through cmd_type / status_type.
module tkri_datapath #(
   parameter int MAX_RANK = tkri_pkg::MAX_RANK_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tkri_pkg::cmd_type            cmd,
   output tkri_pkg::status_type         status,
   input  logic                         csr_we,
   input  logic [tkri_pkg::RANK_W-1:0]  csr_rank_length,
   input  logic [tkri_pkg::SCORE_W-1:0] req_score,
   input  logic [tkri_pkg::INDEX_W-1:0] req_graph_index,
   output logic [tkri_pkg::POS_W-1:0]   rsp_rank_position,
   output logic [tkri_pkg::INDEX_W-1:0] rsp_ranked_index,
   output logic                         rsp_last
);
   import tkri_pkg::*;

   localparam int LW = $clog2(MAX_RANK + 1);
   localparam int EW = (LW > RANK_W) ? LW : RANK_W;

   logic [RANK_W-1:0]  rank_ff, rank_in;
   logic [LW-1:0]      fill_ff, fill_in;
   logic [LW-1:0]      cnt_ff, cnt_in;
   logic [LW-1:0]      pos_ff, pos_in;
   logic [SCORE_W-1:0] score_ff, score_in;
   logic [INDEX_W-1:0] gidx_ff, gidx_in;
   logic [MAX_RANK-1:0] le_ff, le_in;

   logic [SCORE_W-1:0] kscore_ff [MAX_RANK];
   logic [SCORE_W-1:0] kscore_in [MAX_RANK];
   logic [INDEX_W-1:0] kidx_ff   [MAX_RANK];
   logic [INDEX_W-1:0] kidx_in   [MAX_RANK];
   logic [INDEX_W-1:0] list_ff   [MAX_RANK];
   logic [INDEX_W-1:0] list_in   [MAX_RANK];

   logic [LW-1:0]       eff_len;
   logic [LW-1:0]       limit;
   logic [MAX_RANK-1:0] in_len;
   logic                do_insert;

   // rank_length 0 acts as 1, above MAX_RANK acts as MAX_RANK
   always_comb begin
      if (rank_ff == '0) begin
         eff_len = LW'(1);
      end else if (EW'(rank_ff) > EW'(MAX_RANK)) begin
         eff_len = LW'(MAX_RANK);
      end else begin
         eff_len = LW'(rank_ff);
      end
      limit = (fill_ff < eff_len) ? fill_ff : eff_len;
   end

   // le_ff[i]: entry i is visible and its score <= new score (a prefix mask)
   for (genvar i = 0; i < MAX_RANK; i++) begin : g_cell
      logic prev_le;
      assign in_len[i] = LW'(i) < eff_len;
      assign le_in[i]  = cmd.compare ? ((LW'(i) < limit) && (score_ff >= kscore_ff[i]))
                                     : le_ff[i];
      if (i == 0) begin : g_first
         assign prev_le = 1'b1;
      end else begin : g_rest
         assign prev_le = le_ff[i-1];
      end

      always_comb begin
         kscore_in[i] = kscore_ff[i];
         kidx_in[i]   = kidx_ff[i];
         if (do_insert) begin
            if (prev_le && !le_ff[i]) begin
               kscore_in[i] = score_ff;
               kidx_in[i]   = gidx_ff;
            end else if (!prev_le) begin
               if (i > 0) begin
                  kscore_in[i] = kscore_ff[(i > 0) ? i - 1 : 0];
                  kidx_in[i]   = kidx_ff[(i > 0) ? i - 1 : 0];
               end
            end
         end
      end

      always_comb begin
         list_in[i] = list_ff[i];
         if (cmd.load) begin
            list_in[i] = kidx_ff[i];
         end else if (cmd.emit) begin
            if (i < MAX_RANK - 1) begin
               list_in[i] = list_ff[(i < MAX_RANK - 1) ? i + 1 : i];
            end
         end
      end
   end

   // the pair is kept when some visible-length slot is empty or holds a higher score
   assign do_insert = cmd.insert && |(~le_ff & in_len);

   always_comb begin
      rank_in  = csr_we ? csr_rank_length : rank_ff;
      score_in = cmd.capture ? req_score : score_ff;
      gidx_in  = cmd.capture ? req_graph_index : gidx_ff;
      fill_in  = fill_ff;
      if (do_insert && (fill_ff != LW'(MAX_RANK))) begin
         fill_in = fill_ff + LW'(1);
      end
      cnt_in = cnt_ff;
      pos_in = pos_ff;
      if (cmd.load) begin
         cnt_in = limit;
         pos_in = '0;
      end else if (cmd.emit) begin
         pos_in = pos_ff + LW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff <= RANK_RESET;
         fill_ff <= '0;
      end else begin
         rank_ff <= rank_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      score_ff  <= score_in;
      gidx_ff   <= gidx_in;
      le_ff     <= le_in;
      cnt_ff    <= cnt_in;
      pos_ff    <= pos_in;
      kscore_ff <= kscore_in;
      kidx_ff   <= kidx_in;
      list_ff   <= list_in;
   end

   assign status.list_done  = (pos_ff == cnt_ff - LW'(1));
   assign rsp_rank_position = POS_W'(pos_ff);
   assign rsp_ranked_index  = list_ff[0];
   assign rsp_last          = status.list_done;

endmodule

FILE: hw/rtl/top_k_ranking_insert.sv
// Top-k ranking insert: an accepted item passes through the compare, insert and load
// states; the listing then gives min(fill, effective rank_length) results, one per cycle.
// The block stays busy, and takes no new item, until the listing sweep over the kept
// entries has ended.
// Synchronous reset empties the ranking and sets rank_length to 16.
// Results are strobed on rsp_valid for one cycle each; no back-pressure.
module top_k_ranking_insert #(
   parameter int MAX_RANK = tkri_pkg::MAX_RANK_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [tkri_pkg::SCORE_W-1:0] req_score,
   input  logic [tkri_pkg::INDEX_W-1:0] req_graph_index,
   output logic                         rsp_valid,
   output logic [tkri_pkg::POS_W-1:0]   rsp_rank_position,
   output logic [tkri_pkg::INDEX_W-1:0] rsp_ranked_index,
   output logic                         rsp_last,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [tkri_pkg::RANK_W-1:0]  csr_rank_length
);
   import tkri_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = !busy;

   tkri_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   tkri_datapath #(
      .MAX_RANK (MAX_RANK)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_we            (csr_valid && csr_ready),
      .csr_rank_length   (csr_rank_length),
      .req_score         (req_score),
      .req_graph_index   (req_graph_index),
      .rsp_rank_position (rsp_rank_position),
      .rsp_ranked_index  (rsp_ranked_index),
      .rsp_last          (rsp_last)
   );

endmodule

FILE: hw/rtl/tkri_checker.sv
// Port-level checks for top_k_ranking_insert, attached by bind.
// Depends on tkri_pkg for field widths.
module tkri_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         rsp_valid,
   input logic [tkri_pkg::POS_W-1:0]   rsp_rank_position,
   input logic                         rsp_last
);
   import tkri_pkg::*;

   // results only while an item is in flight
   a_rsp_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   // a listing starts at rank 0
   a_list_first: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> (rsp_rank_position == '0))
      else $error("listing does not start at position 0");

   // a listing runs without gaps, one position per transfer
   a_list_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=>
         (rsp_valid && (rsp_rank_position == $past(rsp_rank_position) + POS_W'(1))))
      else $error("listing gap or position skip");

   // the last transfer ends the listing
   a_list_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> !rsp_valid)
      else $error("result after last");

   // an accepted item keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

endmodule

bind top_k_ranking_insert tkri_checker u_tkri_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_rank_position (rsp_rank_position),
   .rsp_last          (rsp_last)
);
